// File: hdl/psgr_pkg.sv
// Shared types, codes and the control store of the packet sequence gap recovery core.
// Used by psgr_sequencer, psgr_datapath and the top level; depends on nothing else.
package psgr_pkg;

  // Fixed limits of the recovery planner.
  localparam int unsigned WIRE_SLOTS      = 3;
  localparam int unsigned PIGGYBACK_SLOTS = 3;
  localparam int unsigned NUM_SLOTS       =
      (PIGGYBACK_SLOTS < WIRE_SLOTS) ? PIGGYBACK_SLOTS : WIRE_SLOTS;
  localparam logic [5:0]  MAX_RECOVER     = 6'd32;
  localparam logic [7:0]  STALE_GAP       = 8'd128;

  localparam logic [7:0]  RESYNC_GAP_RST  = 8'd16;
  localparam logic [5:0]  RECOVER_CAP_RST = 6'd8;

  // Restart request codes: any nonzero kind restarts, bit 1 requests the fade.
  localparam logic [1:0]  RK_NONE     = 2'd0;
  localparam logic [1:0]  RK_RESTART  = 2'd1;
  localparam logic [1:0]  RK_SOURCE   = 2'd2;
  localparam int unsigned RK_FADE_BIT = 1;

  // Configuration register indexes.
  typedef enum logic {
    REG_RESYNC_GAP  = 1'b0,
    REG_RECOVER_CAP = 1'b1
  } reg_idx_e;

  // Action codes on the result channel.
  typedef enum logic [1:0] {
    ACT_RECOVER = 2'd0,
    ACT_CONCEAL = 2'd1,
    ACT_PLAY    = 2'd2
  } action_e;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLASSIFY,
    OP_EMIT_LOOP,
    OP_EMIT_SINGLE,
    OP_EMIT_PLAY
  } op_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_IN,
    C_NO_LOSS,
    C_SINGLE,
    C_CNT_ZERO,
    C_LOOP_MORE
  } cond_e;

  typedef logic [2:0] step_t;

  localparam step_t STEP_FETCH    = 3'd0;
  localparam step_t STEP_CLASSIFY = 3'd1;
  localparam step_t STEP_PATH     = 3'd2;
  localparam step_t STEP_CNT      = 3'd3;
  localparam step_t STEP_LOOP     = 3'd4;
  localparam step_t STEP_PLAY     = 3'd5;
  localparam step_t STEP_SINGLE   = 3'd6;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_e  op;
    logic fire;
  } ctrl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic no_loss;
    logic single;
    logic cnt_zero;
    logic loop_more;
    logic out_free;
  } status_t;

  // Control store. A step falls through to the next address unless its
  // condition holds, in which case it jumps to the target.
  function automatic ucode_t ucode(step_t pc);
    ucode_t w;
    unique case (pc)
      STEP_FETCH:    w = '{op: OP_CAPTURE,     cond: C_NO_IN,     target: STEP_FETCH};
      STEP_CLASSIFY: w = '{op: OP_CLASSIFY,    cond: C_NO_LOSS,   target: STEP_PLAY};
      STEP_PATH:     w = '{op: OP_NONE,        cond: C_SINGLE,    target: STEP_SINGLE};
      STEP_CNT:      w = '{op: OP_NONE,        cond: C_CNT_ZERO,  target: STEP_PLAY};
      STEP_LOOP:     w = '{op: OP_EMIT_LOOP,   cond: C_LOOP_MORE, target: STEP_LOOP};
      STEP_PLAY:     w = '{op: OP_EMIT_PLAY,   cond: C_ALWAYS,    target: STEP_FETCH};
      STEP_SINGLE:   w = '{op: OP_EMIT_SINGLE, cond: C_ALWAYS,    target: STEP_PLAY};
      default:       w = '{op: OP_NONE,        cond: C_ALWAYS,    target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/packet_sequence_gap_recovery_core.sv
// A request is taken in the fetch step; its results are registered after the classify
// step (on loss also the path step, and the count step on multi-entry loss), then one
// per cycle while the output register is free. A new request is taken only after the
// play action; on multi-entry loss cnt = min(gap, recover_cap, 32) loop results precede it.
// Reset is asynchronous and active low: step counter, statistics and lock cleared,
// resync_gap 16 and recover_cap 8; there is no clearing pass.
module packet_sequence_gap_recovery_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  seq_i,
  input  logic [1:0]  pb_entries_i,
  input  logic [7:0]  pb_seq_0_i,
  input  logic [7:0]  pb_seq_1_i,
  input  logic [7:0]  pb_seq_2_i,
  input  logic        single_entry_path_i,
  input  logic [1:0]  restart_kind_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [1:0]  slot_o,
  output logic [7:0]  frame_seq_o,
  output logic [6:0]  conceal_packets_o,
  output logic        restart_fade_o,
  output logic        last_o,
  output logic [31:0] total_received_o,
  output logic [31:0] total_lost_o,
  output logic [6:0]  max_run_lost_o,
  output logic [31:0] total_resyncs_o,
  output logic [31:0] total_recovered_o
);

  psgr_pkg::ctrl_t   ctrl;
  psgr_pkg::status_t status;

  psgr_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o)
  );

  psgr_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .ctrl_i              (ctrl),
    .status_o            (status),
    .seq_i               (seq_i),
    .pb_entries_i        (pb_entries_i),
    .pb_seq_0_i          (pb_seq_0_i),
    .pb_seq_1_i          (pb_seq_1_i),
    .pb_seq_2_i          (pb_seq_2_i),
    .single_entry_path_i (single_entry_path_i),
    .restart_kind_i      (restart_kind_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .action_o            (action_o),
    .slot_o              (slot_o),
    .frame_seq_o         (frame_seq_o),
    .conceal_packets_o   (conceal_packets_o),
    .restart_fade_o      (restart_fade_o),
    .last_o              (last_o),
    .total_received_o    (total_received_o),
    .total_lost_o        (total_lost_o),
    .max_run_lost_o      (max_run_lost_o),
    .total_resyncs_o     (total_resyncs_o),
    .total_recovered_o   (total_recovered_o)
  );

`ifndef SYNTH
  // The play action, and only it, closes a packet's run.
  a_last_is_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((action_o == psgr_pkg::ACT_PLAY) == last_o))
    else $error("last flag does not match the play action");

  // A recovery uses a real slot and conceals nothing.
  a_recover_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == psgr_pkg::ACT_RECOVER)) |->
      ((conceal_packets_o == 7'd0) && (slot_o != 2'd3)))
    else $error("recover action with bad slot or conceal length");

  // A new request is taken only once the previous plan has reached its play action.
  a_accept_after_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (!out_valid_o || last_o))
    else $error("request taken while a plan is still being emitted");
`endif

endmodule

// File: hdl/psgr_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on psgr_pkg for the control word, condition codes and status struct.
module psgr_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  psgr_pkg::status_t status_i,
  output psgr_pkg::ctrl_t   ctrl_o,
  output logic              in_stall_o
);

  psgr_pkg::step_t  pc_q, pc_d;
  psgr_pkg::ucode_t word;
  logic             is_emit;
  logic             hold;
  logic             take;

  assign word = psgr_pkg::ucode(pc_q);

  assign is_emit = (word.op == psgr_pkg::OP_EMIT_LOOP)   ||
                   (word.op == psgr_pkg::OP_EMIT_SINGLE) ||
                   (word.op == psgr_pkg::OP_EMIT_PLAY);

  // An emitting step waits until the output register can take its result.
  assign hold = is_emit && !status_i.out_free;

  always_comb begin
    unique case (word.cond)
      psgr_pkg::C_ALWAYS:    take = 1'b1;
      psgr_pkg::C_NO_IN:     take = !in_valid_i;
      psgr_pkg::C_NO_LOSS:   take = status_i.no_loss;
      psgr_pkg::C_SINGLE:    take = status_i.single;
      psgr_pkg::C_CNT_ZERO:  take = status_i.cnt_zero;
      psgr_pkg::C_LOOP_MORE: take = status_i.loop_more;
      default:               take = 1'b1;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= psgr_pkg::STEP_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op   = word.op;
  assign ctrl_o.fire = (word.op == psgr_pkg::OP_CAPTURE) ? in_valid_i : !hold;
  assign in_stall_o  = (word.op != psgr_pkg::OP_CAPTURE);

endmodule

// File: hdl/psgr_datapath.sv
// Datapath: configuration registers, captured header, gap classification,
// loss statistics, action generation and the result register.
// Depends on psgr_pkg; steered by psgr_sequencer through ctrl_t.
module psgr_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  psgr_pkg::ctrl_t   ctrl_i,
  output psgr_pkg::status_t status_o,
  input  logic [7:0]        seq_i,
  input  logic [1:0]        pb_entries_i,
  input  logic [7:0]        pb_seq_0_i,
  input  logic [7:0]        pb_seq_1_i,
  input  logic [7:0]        pb_seq_2_i,
  input  logic              single_entry_path_i,
  input  logic [1:0]        restart_kind_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        action_o,
  output logic [1:0]        slot_o,
  output logic [7:0]        frame_seq_o,
  output logic [6:0]        conceal_packets_o,
  output logic              restart_fade_o,
  output logic              last_o,
  output logic [31:0]       total_received_o,
  output logic [31:0]       total_lost_o,
  output logic [6:0]        max_run_lost_o,
  output logic [31:0]       total_resyncs_o,
  output logic [31:0]       total_recovered_o
);

  localparam int unsigned NS = psgr_pkg::WIRE_SLOTS;

  // Configuration.
  logic [7:0]  resync_gap_q;
  logic [5:0]  recover_cap_q;

  // Sequence state and statistics.
  logic [7:0]  exp_q;
  logic        seq_valid_q;
  logic [31:0] received_q;
  logic [31:0] lost_q;
  logic [6:0]  max_gap_q;
  logic [31:0] resync_q;
  logic [31:0] recovered_q;

  // Captured header.
  logic [7:0]  seq_q;
  logic [1:0]  pbc_q;
  logic [7:0]  pb_q [NS];
  logic        single_q;
  logic [1:0]  rk_q;

  // Per-packet plan.
  logic [5:0]  cnt_q;
  logic [5:0]  idx_q;
  logic [7:0]  gap_q;
  logic [7:0]  first_q;
  logic        hit_q;
  logic        fade_q;

  // Result register.
  logic        out_valid_q;
  logic [1:0]  act_q;
  logic [1:0]  slot_q;
  logic [7:0]  fseq_q;
  logic [6:0]  cpk_q;
  logic        fade_out_q;
  logic        last_q;
  logic [31:0] o_rx_q;
  logic [31:0] o_lost_q;
  logic [6:0]  o_max_q;
  logic [31:0] o_resync_q;
  logic [31:0] o_rec_q;

  // Classification.
  logic        valid_eff;
  logic [7:0]  gap;
  logic [7:0]  thr;
  logic        quiet;
  logic        splice;
  logic        loss;
  logic [5:0]  cap_sat;
  logic [5:0]  cnt;
  logic        single_hit;
  logic        slot_act [NS];
  logic [7:0]  pb_age [NS];
  logic        in_win [NS];
  logic        dup [NS];
  logic [1:0]  rec_n;
  logic [1:0]  rec_inc;

  // Action generation.
  logic [7:0]  fs;
  logic        found;
  logic [1:0]  found_slot;
  logic        emit;
  logic [1:0]  act_d;
  logic [1:0]  slot_d;
  logic [7:0]  fseq_d;
  logic [6:0]  cpk_d;
  logic        last_d;

  logic        do_capture;
  logic        do_classify;
  logic        do_loop;
  logic        out_free;

  assign do_capture  = ctrl_i.fire && (ctrl_i.op == psgr_pkg::OP_CAPTURE);
  assign do_classify = ctrl_i.fire && (ctrl_i.op == psgr_pkg::OP_CLASSIFY);
  assign do_loop     = ctrl_i.fire && (ctrl_i.op == psgr_pkg::OP_EMIT_LOOP);
  assign emit        = ctrl_i.fire && (ctrl_i.op inside {psgr_pkg::OP_EMIT_LOOP,
                                                         psgr_pkg::OP_EMIT_SINGLE,
                                                         psgr_pkg::OP_EMIT_PLAY});
  assign out_free    = !out_valid_q || !out_stall_i;

  // A restart request drops the sequence lock before the packet is judged.
  always_comb begin
    valid_eff  = seq_valid_q && (rk_q == psgr_pkg::RK_NONE);
    gap        = seq_q - exp_q;
    thr        = (resync_gap_q == 8'd0) ? 8'd1 : resync_gap_q;
    quiet      = (gap == 8'd0) || (gap >= psgr_pkg::STALE_GAP);
    splice     = valid_eff && !quiet && (gap >= thr);
    loss       = valid_eff && !quiet && (gap < thr);
    cap_sat    = (recover_cap_q > psgr_pkg::MAX_RECOVER) ? psgr_pkg::MAX_RECOVER
                                                         : recover_cap_q;
    cnt        = (gap > {2'b00, cap_sat}) ? cap_sat : gap[5:0];
    single_hit = (gap == 8'd1) && (pbc_q != 2'd0) && (pb_q[0] == exp_q);
  end

  // Recovered packets on the multi-entry path: distinct active entries that
  // fall inside the window of missing numbers that get an action.
  always_comb begin
    rec_n = 2'd0;
    for (int j = 0; j < NS; j++) begin
      slot_act[j] = (j < psgr_pkg::NUM_SLOTS) && (2'(j) < pbc_q);
      pb_age[j]   = seq_q - pb_q[j];
      in_win[j]   = (pb_age[j] != 8'd0) && (pb_age[j] <= {2'b00, cnt});
      dup[j]      = 1'b0;
      for (int k = 0; k < j; k++) begin
        if (slot_act[k] && (pb_q[k] == pb_q[j])) begin
          dup[j] = 1'b1;
        end
      end
      if (slot_act[j] && in_win[j] && !dup[j]) begin
        rec_n = rec_n + 2'd1;
      end
    end
    if (!loss) begin
      rec_inc = 2'd0;
    end else if (single_q) begin
      rec_inc = {1'b0, single_hit};
    end else begin
      rec_inc = rec_n;
    end
  end

  // Slot search for the current loop action; the lowest matching slot wins.
  always_comb begin
    fs         = seq_q - {2'b00, cnt_q} + {2'b00, idx_q};
    found      = 1'b0;
    found_slot = 2'd0;
    for (int j = NS - 1; j >= 0; j--) begin
      if (slot_act[j] && (pb_q[j] == fs)) begin
        found      = 1'b1;
        found_slot = 2'(j);
      end
    end
  end

  always_comb begin
    unique case (ctrl_i.op)
      psgr_pkg::OP_EMIT_LOOP: begin
        act_d  = found ? psgr_pkg::ACT_RECOVER : psgr_pkg::ACT_CONCEAL;
        slot_d = found_slot;
        fseq_d = fs;
        cpk_d  = found ? 7'd0 : 7'd1;
        last_d = 1'b0;
      end
      psgr_pkg::OP_EMIT_SINGLE: begin
        act_d  = hit_q ? psgr_pkg::ACT_RECOVER : psgr_pkg::ACT_CONCEAL;
        slot_d = 2'd0;
        fseq_d = first_q;
        cpk_d  = hit_q ? 7'd0 : gap_q[6:0];
        last_d = 1'b0;
      end
      default: begin
        act_d  = psgr_pkg::ACT_PLAY;
        slot_d = 2'd0;
        fseq_d = seq_q;
        cpk_d  = 7'd0;
        last_d = 1'b1;
      end
    endcase
  end

  // Control state, configuration and statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resync_gap_q  <= psgr_pkg::RESYNC_GAP_RST;
      recover_cap_q <= psgr_pkg::RECOVER_CAP_RST;
      exp_q         <= 8'd0;
      seq_valid_q   <= 1'b0;
      received_q    <= 32'd0;
      lost_q        <= 32'd0;
      max_gap_q     <= 7'd0;
      resync_q      <= 32'd0;
      recovered_q   <= 32'd0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (psgr_pkg::reg_idx_e'(cfg_idx_i))
          psgr_pkg::REG_RESYNC_GAP:  resync_gap_q  <= cfg_wdata_i;
          psgr_pkg::REG_RECOVER_CAP: recover_cap_q <= cfg_wdata_i[5:0];
          default:                   resync_gap_q  <= resync_gap_q;
        endcase
      end
      if (do_classify) begin
        seq_valid_q <= 1'b1;
        exp_q       <= seq_q + 8'd1;
        received_q  <= received_q + 32'd1;
        recovered_q <= recovered_q + {30'd0, rec_inc};
        if (splice) begin
          resync_q <= resync_q + 32'd1;
        end
        if (loss) begin
          lost_q <= lost_q + {24'd0, gap};
          if (gap[6:0] > max_gap_q) begin
            max_gap_q <= gap[6:0];
          end
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (do_capture) begin
      seq_q    <= seq_i;
      pbc_q    <= pb_entries_i;
      pb_q[0]  <= pb_seq_0_i;
      pb_q[1]  <= pb_seq_1_i;
      pb_q[2]  <= pb_seq_2_i;
      single_q <= single_entry_path_i;
      rk_q     <= restart_kind_i;
    end
    if (do_classify) begin
      cnt_q   <= cnt;
      idx_q   <= 6'd0;
      gap_q   <= gap;
      first_q <= exp_q;
      hit_q   <= single_hit;
      fade_q  <= rk_q[psgr_pkg::RK_FADE_BIT] || splice;
    end else if (do_loop) begin
      idx_q <= idx_q + 6'd1;
    end
    // Statistics are copied with each result so a stalled result holds still.
    if (emit) begin
      act_q      <= act_d;
      slot_q     <= slot_d;
      fseq_q     <= fseq_d;
      cpk_q      <= cpk_d;
      last_q     <= last_d;
      fade_out_q <= fade_q;
      o_rx_q     <= received_q;
      o_lost_q   <= lost_q;
      o_max_q    <= max_gap_q;
      o_resync_q <= resync_q;
      o_rec_q    <= recovered_q;
    end
  end

  assign status_o.no_loss   = !loss;
  assign status_o.single    = single_q;
  assign status_o.cnt_zero  = (cnt_q == 6'd0);
  assign status_o.loop_more = ({1'b0, idx_q} + 7'd1) < {1'b0, cnt_q};
  assign status_o.out_free  = out_free;

  assign out_valid_o       = out_valid_q;
  assign action_o          = act_q;
  assign slot_o            = slot_q;
  assign frame_seq_o       = fseq_q;
  assign conceal_packets_o = cpk_q;
  assign restart_fade_o    = fade_out_q;
  assign last_o            = last_q;
  assign total_received_o  = o_rx_q;
  assign total_lost_o      = o_lost_q;
  assign max_run_lost_o    = o_max_q;
  assign total_resyncs_o   = o_resync_q;
  assign total_recovered_o = o_rec_q;

endmodule

// File: tb/packet_sequence_gap_recovery_core_test.sv
// Self-checking testbench for the packet sequence gap recovery core: a directed table,
// then random packet streams under several register settings and idling patterns.
// Depends on psgr_pkg and packet_sequence_gap_recovery_core only.
module packet_sequence_gap_recovery_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT     = 1000;
  localparam int unsigned ITEMS_PER_PHASE = 19;

  // One packet header as presented on the request channel.
  typedef struct packed {
    logic [7:0]      seq;
    logic [1:0]      pb_entries;
    logic [2:0][7:0] pb_seq;
    logic            single;
    logic [1:0]      restart_kind;
  } pkt_t;

  // One planned action as it appears on the result channel.
  typedef struct packed {
    psgr_pkg::action_e action;
    logic [1:0]        slot;
    logic [7:0]        frame_seq;
    logic [6:0]        conceal_packets;
    logic              restart_fade;
    logic              last;
    logic [31:0]       total_received;
    logic [31:0]       total_lost;
    logic [6:0]        max_run_lost;
    logic [31:0]       total_resyncs;
    logic [31:0]       total_recovered;
  } plan_t;

  // A stimulus row; typed rows carry their single expected action.
  typedef struct {
    pkt_t  pkt;
    bit    typed;
    plan_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  seq_i = '0;
  logic [1:0]  pb_entries_i = '0;
  logic [7:0]  pb_seq_0_i = '0;
  logic [7:0]  pb_seq_1_i = '0;
  logic [7:0]  pb_seq_2_i = '0;
  logic        single_entry_path_i = 1'b0;
  logic [1:0]  restart_kind_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  action_o;
  logic [1:0]  slot_o;
  logic [7:0]  frame_seq_o;
  logic [6:0]  conceal_packets_o;
  logic        restart_fade_o;
  logic        last_o;
  logic [31:0] total_received_o;
  logic [31:0] total_lost_o;
  logic [6:0]  max_run_lost_o;
  logic [31:0] total_resyncs_o;
  logic [31:0] total_recovered_o;

  packet_sequence_gap_recovery_core i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .seq_i               (seq_i),
    .pb_entries_i        (pb_entries_i),
    .pb_seq_0_i          (pb_seq_0_i),
    .pb_seq_1_i          (pb_seq_1_i),
    .pb_seq_2_i          (pb_seq_2_i),
    .single_entry_path_i (single_entry_path_i),
    .restart_kind_i      (restart_kind_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .action_o            (action_o),
    .slot_o              (slot_o),
    .frame_seq_o         (frame_seq_o),
    .conceal_packets_o   (conceal_packets_o),
    .restart_fade_o      (restart_fade_o),
    .last_o              (last_o),
    .total_received_o    (total_received_o),
    .total_lost_o        (total_lost_o),
    .max_run_lost_o      (max_run_lost_o),
    .total_resyncs_o     (total_resyncs_o),
    .total_recovered_o   (total_recovered_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Planner state and register copies, tracked at request acceptance.
  logic [7:0]  resync_gap_r  = psgr_pkg::RESYNC_GAP_RST;
  logic [5:0]  recover_cap_r = psgr_pkg::RECOVER_CAP_RST;
  logic [7:0]  exp_seq       = '0;
  logic        seq_locked    = 1'b0;
  logic [31:0] rx_total      = '0;
  logic [31:0] lost_total    = '0;
  logic [6:0]  max_gap       = '0;
  logic [31:0] resync_total  = '0;
  logic [31:0] recov_total   = '0;

  plan_t       step_actions[$];
  plan_t       pending_actions[$];
  row_t        dir_rows[$];
  plan_t       got_act;
  plan_t       want_act;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;

  function automatic plan_t action_entry(psgr_pkg::action_e a, logic [1:0] slot,
                                         logic [7:0] fseq, logic [6:0] cpk);
    plan_t e;
    e = '0;
    e.action          = a;
    e.slot            = slot;
    e.frame_seq       = fseq;
    e.conceal_packets = cpk;
    return e;
  endfunction

  // Plans the actions for one accepted packet into step_actions and advances the state.
  function automatic void plan_packet(pkt_t p);
    logic [7:0]  gap;
    logic [7:0]  thr;
    logic [7:0]  s;
    logic [5:0]  cap;
    logic [6:0]  cnt;
    logic        fade;
    int unsigned nsl;
    int          hit;
    step_actions.delete();
    nsl = (p.pb_entries < psgr_pkg::NUM_SLOTS) ? p.pb_entries : psgr_pkg::NUM_SLOTS;
    if (p.restart_kind != psgr_pkg::RK_NONE) seq_locked = 1'b0;
    fade = p.restart_kind[psgr_pkg::RK_FADE_BIT];
    rx_total = rx_total + 1;
    if (seq_locked) begin
      gap = p.seq - exp_seq;
      thr = (resync_gap_r == 8'd0) ? 8'd1 : resync_gap_r;
      if (gap == 8'd0 || gap >= psgr_pkg::STALE_GAP) begin
        // In order or stale: only the current packet is played.
      end else if (gap >= thr) begin
        resync_total = resync_total + 1;
        fade = 1'b1;
      end else begin
        lost_total = lost_total + 32'(gap);
        if (gap[6:0] > max_gap) max_gap = gap[6:0];
        if (!p.single) begin
          cap = (recover_cap_r > psgr_pkg::MAX_RECOVER) ? psgr_pkg::MAX_RECOVER
                                                        : recover_cap_r;
          cnt = (gap > 8'(cap)) ? 7'(cap) : gap[6:0];
          for (int i = 0; i < int'(cnt); i++) begin
            s = p.seq - 8'(cnt) + 8'(i);
            hit = -1;
            for (int j = 0; j < int'(nsl); j++) begin
              if (hit < 0 && p.pb_seq[j] == s) hit = j;
            end
            if (hit >= 0) begin
              step_actions.push_back(action_entry(psgr_pkg::ACT_RECOVER, 2'(hit), s, 7'd0));
              recov_total = recov_total + 1;
            end else begin
              step_actions.push_back(action_entry(psgr_pkg::ACT_CONCEAL, 2'd0, s, 7'd1));
            end
          end
        end else if (gap == 8'd1 && p.pb_entries != 2'd0 && p.pb_seq[0] == exp_seq) begin
          step_actions.push_back(action_entry(psgr_pkg::ACT_RECOVER, 2'd0, exp_seq, 7'd0));
          recov_total = recov_total + 1;
        end else begin
          step_actions.push_back(action_entry(psgr_pkg::ACT_CONCEAL, 2'd0, exp_seq,
                                              gap[6:0]));
        end
      end
    end
    seq_locked = 1'b1;
    exp_seq = p.seq + 8'd1;
    step_actions.push_back(action_entry(psgr_pkg::ACT_PLAY, 2'd0, p.seq, 7'd0));
    step_actions[step_actions.size() - 1].last = 1'b1;
    // Statistics after the whole packet are repeated on every action.
    foreach (step_actions[k]) begin
      step_actions[k].restart_fade    = fade;
      step_actions[k].total_received  = rx_total;
      step_actions[k].total_lost      = lost_total;
      step_actions[k].max_run_lost    = max_gap;
      step_actions[k].total_resyncs   = resync_total;
      step_actions[k].total_recovered = recov_total;
    end
  endfunction

  function automatic row_t req_row(logic [7:0] seq, logic [1:0] pbc, logic [7:0] p0,
                                   logic [7:0] p1, logic [7:0] p2, logic single,
                                   logic [1:0] rk);
    row_t r;
    r.pkt.seq          = seq;
    r.pkt.pb_entries   = pbc;
    r.pkt.pb_seq[0]    = p0;
    r.pkt.pb_seq[1]    = p1;
    r.pkt.pb_seq[2]    = p2;
    r.pkt.single       = single;
    r.pkt.restart_kind = rk;
    r.typed            = 1'b0;
    r.want             = '0;
    return r;
  endfunction

  // A row whose only action is the play of the current packet with clean statistics.
  function automatic row_t play_row(row_t r, logic fade, logic [31:0] received);
    r.typed                = 1'b1;
    r.want                 = action_entry(psgr_pkg::ACT_PLAY, 2'd0, r.pkt.seq, 7'd0);
    r.want.last            = 1'b1;
    r.want.restart_fade    = fade;
    r.want.total_received  = received;
    return r;
  endfunction

  // Mostly well-formed streams: in order or short losses, with jumps, stale and restarts.
  function automatic row_t random_row();
    row_t        r;
    logic [7:0]  gap;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) gap = 8'd0;
    else if (pick < 75) gap = ($urandom_range(5) == 0) ? 8'($urandom_range(127, 1))
                                                       : 8'($urandom_range(20, 1));
    else if (pick < 87) gap = 8'($urandom_range(255, 128));
    else gap = 8'($urandom);
    r = req_row(exp_seq + gap, 2'($urandom_range(3)), 8'd0, 8'd0, 8'd0,
                $urandom_range(99) < 30,
                ($urandom_range(99) < 8) ? 2'($urandom_range(3, 1)) : psgr_pkg::RK_NONE);
    for (int j = 0; j < 3; j++) begin
      r.pkt.pb_seq[j] = ($urandom_range(3) == 0) ? 8'($urandom)
                                                 : r.pkt.seq - 8'($urandom_range(12, 1));
    end
    return r;
  endfunction

  task automatic report(string msg);
    mismatches++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h, wanted %0h", name, got, want));
  endtask

  // Starts and ends at a falling edge; valid stays high for a back-to-back request.
  task automatic send_request(row_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    seq_i               <= r.pkt.seq;
    pb_entries_i        <= r.pkt.pb_entries;
    pb_seq_0_i          <= r.pkt.pb_seq[0];
    pb_seq_1_i          <= r.pkt.pb_seq[1];
    pb_seq_2_i          <= r.pkt.pb_seq[2];
    single_entry_path_i <= r.pkt.single;
    restart_kind_i      <= r.pkt.restart_kind;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    plan_packet(r.pkt);
    if (r.typed) pending_actions.push_back(r.want);
    else foreach (step_actions[k]) pending_actions.push_back(step_actions[k]);
    @(negedge clk_i);
  endtask

  task automatic write_reg(psgr_pkg::reg_idx_e idx, logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == psgr_pkg::REG_RESYNC_GAP) resync_gap_r = data;
    else recover_cap_r = data[5:0];
    @(negedge clk_i);
  endtask

  // Lets the block drain before the registers change, then runs one random phase.
  task automatic run_phase(logic [7:0] gap, logic [5:0] cap, int unsigned snd_pct,
                           int unsigned rcv_pct);
    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(psgr_pkg::REG_RESYNC_GAP, gap);
    write_reg(psgr_pkg::REG_RECOVER_CAP, {2'b00, cap});
    cfg_we_i      <= 1'b0;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    repeat (ITEMS_PER_PHASE) send_request(random_row());
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_act.action          = psgr_pkg::action_e'(action_o);
      got_act.slot            = slot_o;
      got_act.frame_seq       = frame_seq_o;
      got_act.conceal_packets = conceal_packets_o;
      got_act.restart_fade    = restart_fade_o;
      got_act.last            = last_o;
      got_act.total_received  = total_received_o;
      got_act.total_lost      = total_lost_o;
      got_act.max_run_lost    = max_run_lost_o;
      got_act.total_resyncs   = total_resyncs_o;
      got_act.total_recovered = total_recovered_o;
      if (pending_actions.size() == 0) begin
        report($sformatf("unrequested action %0h for frame %0h", action_o, frame_seq_o));
      end else begin
        want_act = pending_actions.pop_front();
        check_field("action", 32'(got_act.action), 32'(want_act.action));
        check_field("slot", 32'(got_act.slot), 32'(want_act.slot));
        check_field("frame_seq", 32'(got_act.frame_seq), 32'(want_act.frame_seq));
        check_field("conceal_packets", 32'(got_act.conceal_packets),
                    32'(want_act.conceal_packets));
        check_field("restart_fade", 32'(got_act.restart_fade), 32'(want_act.restart_fade));
        check_field("last", 32'(got_act.last), 32'(want_act.last));
        check_field("total_received", got_act.total_received, want_act.total_received);
        check_field("total_lost", got_act.total_lost, want_act.total_lost);
        check_field("max_run_lost", 32'(got_act.max_run_lost), 32'(want_act.max_run_lost));
        check_field("total_resyncs", got_act.total_resyncs, want_act.total_resyncs);
        check_field("total_recovered", got_act.total_recovered, want_act.total_recovered);
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // Directed rows run with the reset register values: splice at 16, cap of 8.
    dir_rows.push_back(play_row(req_row(8'hFF, 2'd3, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                                        psgr_pkg::RK_NONE), 1'b0, 32'd1));
    // Kind 3 restarts and also raises the fade.
    dir_rows.push_back(play_row(req_row(8'h00, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0,
                                        psgr_pkg::RK_RESTART | psgr_pkg::RK_SOURCE),
                                1'b1, 32'd2));
    dir_rows.push_back(play_row(req_row(8'h01, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0,
                                        psgr_pkg::RK_NONE), 1'b0, 32'd3));
    dir_rows.push_back(play_row(req_row(8'h01, 2'd2, 8'h55, 8'hAA, 8'h0F, 1'b0,
                                        psgr_pkg::RK_NONE), 1'b0, 32'd4));
    dir_rows.push_back(req_row(8'h04, 2'd3, 8'h03, 8'h02, 8'hAA, 1'b0, psgr_pkg::RK_NONE));
    dir_rows.push_back(req_row(8'h06, 2'd1, 8'h05, 8'h00, 8'h00, 1'b1, psgr_pkg::RK_NONE));
    dir_rows.push_back(req_row(8'h08, 2'd0, 8'h07, 8'h07, 8'h07, 1'b1, psgr_pkg::RK_NONE));
    dir_rows.push_back(req_row(8'h0A, 2'd3, 8'hAA, 8'h09, 8'h09, 1'b1, psgr_pkg::RK_NONE));
    dir_rows.push_back(req_row(8'h10, 2'd3, 8'h0B, 8'h0C, 8'h0D, 1'b1, psgr_pkg::RK_NONE));
    // Gap just under the splice limit; the third entry lies beyond the entry count.
    dir_rows.push_back(req_row(8'h20, 2'd2, 8'h1F, 8'h18, 8'h1E, 1'b0, psgr_pkg::RK_NONE));
    dir_rows.push_back(req_row(8'h31, 2'd3, 8'h30, 8'h2F, 8'h2E, 1'b0, psgr_pkg::RK_NONE));
    dir_rows.push_back(req_row(8'hB2, 2'd3, 8'hB1, 8'hB0, 8'hAF, 1'b0, psgr_pkg::RK_NONE));
    dir_rows.push_back(req_row(8'h32, 2'd3, 8'h31, 8'h30, 8'h2F, 1'b0, psgr_pkg::RK_NONE));
    dir_rows.push_back(req_row(8'hFE, 2'd1, 8'hFD, 8'h00, 8'h00, 1'b0, psgr_pkg::RK_NONE));
    // Missing numbers wrap through zero.
    dir_rows.push_back(req_row(8'h02, 2'd3, 8'hFF, 8'h00, 8'h01, 1'b0, psgr_pkg::RK_NONE));
    // Duplicate entries: the lowest slot wins.
    dir_rows.push_back(req_row(8'h05, 2'd3, 8'h04, 8'h04, 8'h03, 1'b0, psgr_pkg::RK_NONE));
    dir_rows.push_back(req_row(8'h09, 2'd3, 8'h08, 8'h07, 8'h06, 1'b0,
                               psgr_pkg::RK_RESTART));
    dir_rows.push_back(req_row(8'h0D, 2'd3, 8'h0C, 8'h0B, 8'h0A, 1'b0,
                               psgr_pkg::RK_SOURCE));
    dir_rows.push_back(req_row(8'h1D, 2'd1, 8'h0E, 8'h00, 8'h00, 1'b1, psgr_pkg::RK_NONE));
    dir_rows.push_back(req_row(8'h1E, 2'd3, 8'h1D, 8'h1C, 8'h1B, 1'b0, psgr_pkg::RK_NONE));
    dir_rows.push_back(req_row(8'h2C, 2'd3, 8'h2B, 8'h24, 8'h28, 1'b0, psgr_pkg::RK_NONE));

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[i]) send_request(dir_rows[i]);

    run_phase(8'd16, 6'd8, 0, 0);
    run_phase(8'd0, 6'd0, 54, 0);
    run_phase(8'd255, 6'd63, 0, 54);
    run_phase(8'd1, 6'd32, 33, 33);
    run_phase(8'd128, 6'd33, 0, 0);
    run_phase(8'd40, 6'd3, 54, 0);
    run_phase(8'($urandom_range(255, 1)), 6'($urandom_range(63)), 0, 54);
    run_phase(8'd8, 6'd1, 33, 33);

    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
